>>> hdl/assert_macros.svh
// Assertion macros shared by the histogram RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-style check of a condition at every clock edge out of reset
`define UBH_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("histogram assertion failed");

// Overlapping implication: pre at this edge requires post at the same edge
`define UBH_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("histogram assertion failed");

// Next-cycle implication: pre at this edge requires post at the next edge
`define UBH_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("histogram assertion failed");

`endif

>>> hdl/ubh_pkg.sv
// Types and constants of the uniform bin histogram
`timescale 1ns / 1ps

package ubh_pkg;

    localparam int MAX_BINS  = 1024;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int BINS_W    = BIN_W + 1;
    localparam int COUNT_W   = 32;
    localparam int SAMPLE_W  = 32;
    localparam int SPAN_W    = 32;
    localparam int PROD_W    = BINS_W + SPAN_W;
    localparam int DVS_W     = SPAN_W + BIN_W - 1;
    localparam int STEP_W    = $clog2(BIN_W);
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;
    localparam logic [SPAN_W-1:0]    SPAN_RESET    = SPAN_W'(65536);
    localparam logic [BINS_W-1:0]    BINS_RESET    = BINS_W'(MAX_BINS);
    localparam logic [BIN_W-1:0]     LAST_BIN      = BIN_W'(MAX_BINS - 1);
    localparam logic [STEP_W-1:0]    LAST_STEP     = STEP_W'(BIN_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS      = 2'd2;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_READ  = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        ST_SWEEP  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_MUL    = 3'd2,
        ST_DIV    = 3'd3,
        ST_FETCH  = 3'd4,
        ST_UPDATE = 3'd5,
        ST_RDWAIT = 3'd6,
        ST_FINISH = 3'd7
    } state_t;

endpackage

>>> hdl/uniform_bin_histogram.sv
// Uniform bin histogram: bin counters in one RAM, bin index by an iterative divider
//
//  Channel   Ports                        Direction  Beat carries
//  input     s_tvalid s_tready s_tdata    in         sample, read bin; tuser = request
//            s_tuser
//  result    m_tvalid m_tready m_tdata    out        bin number, bin count
//  config    cfg_valid cfg_ready          in         register index and write data
//            cfg_addr cfg_wdata
//
// Add steps: accept, one multiply, 10 divider steps (one quotient bit per cycle),
// RAM read, RAM write, result load. Below the minimum or past the span the divider
// is skipped. Read steps: accept with RAM read, read wait, result load; request
// type 3 goes straight to the result load. Clear and reset both zero the counter RAM,
// one entry per cycle; no beat is accepted meanwhile. Config writes are always taken.
// The result register lets the next beat in while a result waits for m_tready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uniform_bin_histogram (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ubh_pkg::S_DATA_W-1:0]  s_tdata,   // sample_value[31:0], read_bin[41:32]
    input  logic [1:0]                    s_tuser,   // req_type[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ubh_pkg::M_DATA_W-1:0]  m_tdata,   // bin_number[9:0], bin_count[41:10]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ubh_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [31:0]                   cfg_wdata
);

    ubh_pkg::state_t state_reg, state_next;

    logic signed [ubh_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic [ubh_pkg::SPAN_W-1:0]          span_reg, span_next;
    logic [ubh_pkg::BINS_W-1:0]          bins_reg, bins_next;
    logic [ubh_pkg::BINS_W-1:0]          bins_eff;

    logic [ubh_pkg::BIN_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic                        clr_result_reg, clr_result_next;
    logic [ubh_pkg::SPAN_W-1:0]  diff_reg, diff_next;
    logic [ubh_pkg::PROD_W-1:0]  rem_reg, rem_next;
    logic [ubh_pkg::DVS_W-1:0]   dvs_reg, dvs_next;
    logic [ubh_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [ubh_pkg::BIN_W-1:0]   idx_reg, idx_next;
    logic [ubh_pkg::COUNT_W-1:0] cnt_reg, cnt_next;

    logic                        m_valid_reg, m_valid_next;
    logic [ubh_pkg::BIN_W-1:0]   out_num_reg, out_num_next;
    logic [ubh_pkg::COUNT_W-1:0] out_cnt_reg, out_cnt_next;

    logic [ubh_pkg::COUNT_W-1:0] bin_ram [ubh_pkg::MAX_BINS];
    logic [ubh_pkg::COUNT_W-1:0] mem_rdata_reg;
    logic                        mem_we;
    logic [ubh_pkg::BIN_W-1:0]   mem_addr;
    logic [ubh_pkg::COUNT_W-1:0] mem_wdata;

    logic signed [ubh_pkg::SAMPLE_W:0] diff_full;
    logic [ubh_pkg::SAMPLE_W-1:0]      s_sample;
    logic [ubh_pkg::BIN_W-1:0]         s_read_bin;
    logic                              s_accept;
    logic                              div_take;
    logic [ubh_pkg::COUNT_W-1:0]       cnt_inc;

    assign s_sample   = s_tdata[ubh_pkg::SAMPLE_W-1:0];
    assign s_read_bin = s_tdata[ubh_pkg::SAMPLE_W +: ubh_pkg::BIN_W];
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ubh_pkg::M_DATA_W - ubh_pkg::BIN_W - ubh_pkg::COUNT_W){1'b0}},
                       out_cnt_reg, out_num_reg};

    // Zero bins count as one, anything past the store as the store size
    always_comb begin
        if (bins_reg == '0) begin
            bins_eff = ubh_pkg::BINS_W'(1);
        end else if (bins_reg > ubh_pkg::BINS_RESET) begin
            bins_eff = ubh_pkg::BINS_RESET;
        end else begin
            bins_eff = bins_reg;
        end
    end

    assign diff_full = $signed({s_sample[ubh_pkg::SAMPLE_W-1], s_sample})
                     - $signed({min_reg[ubh_pkg::SAMPLE_W-1], min_reg});
    assign div_take  = rem_reg >= {{(ubh_pkg::PROD_W - ubh_pkg::DVS_W){1'b0}}, dvs_reg};
    assign cnt_inc   = (mem_rdata_reg == ubh_pkg::COUNT_MAX) ? mem_rdata_reg
                                                             : mem_rdata_reg + 1'b1;

    always_comb begin
        state_next      = state_reg;
        min_next        = min_reg;
        span_next       = span_reg;
        bins_next       = bins_reg;
        sweep_addr_next = sweep_addr_reg;
        clr_result_next = clr_result_reg;
        diff_next       = diff_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        step_next       = step_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_num_next    = out_num_reg;
        out_cnt_next    = out_cnt_reg;
        s_tready        = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = idx_reg;
        mem_wdata       = '0;

        if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                ubh_pkg::CFG_RANGE_MIN: min_next  = $signed(cfg_wdata);
                ubh_pkg::CFG_SPAN:      span_next = cfg_wdata;
                ubh_pkg::CFG_BINS:      bins_next = cfg_wdata[ubh_pkg::BINS_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ubh_pkg::ST_SWEEP: begin
                mem_we          = 1'b1;
                mem_addr        = sweep_addr_reg;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == ubh_pkg::LAST_BIN) begin
                    state_next = clr_result_reg ? ubh_pkg::ST_FINISH : ubh_pkg::ST_IDLE;
                end
            end
            ubh_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    case (ubh_pkg::req_type_t'(s_tuser))
                        ubh_pkg::REQ_CLEAR: begin
                            sweep_addr_next = '0;
                            clr_result_next = 1'b1;
                            idx_next        = '0;
                            cnt_next        = '0;
                            state_next      = ubh_pkg::ST_SWEEP;
                        end
                        ubh_pkg::REQ_ADD: begin
                            diff_next = diff_full[ubh_pkg::SAMPLE_W-1:0];
                            if (diff_full[ubh_pkg::SAMPLE_W]) begin
                                idx_next   = '0;
                                state_next = ubh_pkg::ST_FETCH;
                            end else if (diff_full[ubh_pkg::SAMPLE_W-1:0] >= span_reg) begin
                                // covers a zero span as well
                                idx_next   = ubh_pkg::BIN_W'(bins_eff - 1'b1);
                                state_next = ubh_pkg::ST_FETCH;
                            end else begin
                                state_next = ubh_pkg::ST_MUL;
                            end
                        end
                        ubh_pkg::REQ_READ: begin
                            mem_addr   = s_read_bin;
                            idx_next   = s_read_bin;
                            state_next = ubh_pkg::ST_RDWAIT;
                        end
                        default: begin
                            idx_next   = '0;
                            cnt_next   = '0;
                            state_next = ubh_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            ubh_pkg::ST_MUL: begin
                rem_next   = ubh_pkg::PROD_W'(bins_eff) * ubh_pkg::PROD_W'(diff_reg);
                dvs_next   = {span_reg, {(ubh_pkg::BIN_W-1){1'b0}}};
                step_next  = '0;
                idx_next   = '0;
                state_next = ubh_pkg::ST_DIV;
            end
            ubh_pkg::ST_DIV: begin
                // quotient is below bins since diff < span: BIN_W bits suffice
                if (div_take) begin
                    rem_next = rem_reg - {{(ubh_pkg::PROD_W - ubh_pkg::DVS_W){1'b0}}, dvs_reg};
                end
                idx_next  = {idx_reg[ubh_pkg::BIN_W-2:0], div_take};
                dvs_next  = dvs_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == ubh_pkg::LAST_STEP) begin
                    state_next = ubh_pkg::ST_FETCH;
                end
            end
            ubh_pkg::ST_FETCH: begin
                mem_addr   = idx_reg;
                state_next = ubh_pkg::ST_UPDATE;
            end
            ubh_pkg::ST_UPDATE: begin
                mem_we     = 1'b1;
                mem_addr   = idx_reg;
                mem_wdata  = cnt_inc;
                cnt_next   = cnt_inc;
                state_next = ubh_pkg::ST_FINISH;
            end
            ubh_pkg::ST_RDWAIT: begin
                cnt_next   = mem_rdata_reg;
                state_next = ubh_pkg::ST_FINISH;
            end
            ubh_pkg::ST_FINISH: begin
                // hold until the result register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    out_num_next    = idx_reg;
                    out_cnt_next    = cnt_reg;
                    clr_result_next = 1'b0;
                    state_next      = ubh_pkg::ST_IDLE;
                end
            end
            default: state_next = ubh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ubh_pkg::ST_SWEEP;
            min_reg        <= '0;
            span_reg       <= ubh_pkg::SPAN_RESET;
            bins_reg       <= ubh_pkg::BINS_RESET;
            sweep_addr_reg <= '0;
            clr_result_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            min_reg        <= min_next;
            span_reg       <= span_next;
            bins_reg       <= bins_next;
            sweep_addr_reg <= sweep_addr_next;
            clr_result_reg <= clr_result_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg    <= diff_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        step_reg    <= step_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        out_num_reg <= out_num_next;
        out_cnt_reg <= out_cnt_next;
    end

    // Single-port counter RAM with a registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bin_ram[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= bin_ram[mem_addr];
    end

    `UBH_ASSERT_IMPL(a_no_accept_in_sweep, state_reg == ubh_pkg::ST_SWEEP, !s_tready)
    `UBH_ASSERT_IMPL(a_incr_nonzero, state_reg == ubh_pkg::ST_UPDATE, mem_we && mem_wdata != '0)
    `UBH_ASSERT_IMPL(a_index_in_range, state_reg == ubh_pkg::ST_FETCH,
                     ubh_pkg::BINS_W'(idx_reg) < bins_eff)
    `UBH_ASSERT_NEXT(a_result_from_finish, !m_valid_reg && state_reg != ubh_pkg::ST_FINISH,
                     !m_valid_reg)
    `UBH_ASSERT_NEXT(a_result_holds, m_valid_reg && !m_tready,
                     m_valid_reg && $stable(out_num_reg) && $stable(out_cnt_reg))

endmodule
